// ===== src/dmc_pkg.sv =====
// Shared types and constants for the 64-bit divide/modulo pipeline.
// No dependencies.
package dmc_pkg;

   localparam int DataWidth = 64;
   localparam int StepCount = DataWidth;

   typedef enum logic [1:0] {
      MODE_UDIV = 2'd0,
      MODE_UREM = 2'd1,
      MODE_SDIV = 2'd2,
      MODE_SREM = 2'd3
   } mode_type;

   // Payload carried down the pipeline; the valid bit travels beside it.
   typedef struct packed {
      mode_type               mode;
      logic                   neg_a;
      logic                   neg_b;
      logic                   zero_div;
      logic [DataWidth-1:0]   rem;      // partial remainder
      logic [DataWidth-1:0]   work;     // dividend bits shifting out, quotient bits in
      logic [DataWidth-1:0]   divisor;  // divisor magnitude
   } stage_type;

endpackage

// ===== src/int64_divide_modulo_core.sv =====
// Top level of the pipelined 64-bit divide/modulo unit.
// Depends on dmc_pkg, dmc_prep, dmc_step, dmc_post.
//
//   channel   ports                                   handshake
//   request   req_mode, req_dividend, req_divisor     start & !busy
//   response  rsp_result                              rsp_valid, one-cycle strobe
//
// One item can enter every cycle. Each item passes through 66 registers in order: one
// entry stage (magnitudes), 64 one-bit restoring steps, one exit stage (sign and select),
// whose register drives the result strobe. Each step is a 66-bit trial subtract.
// Synchronous reset clears the valid bits and sets busy, which clears after reset ends.
// Nothing stalls: the response side always takes its strobe.
module int64_divide_modulo_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [dmc_pkg::DataWidth-1:0] req_dividend,
   input  logic [dmc_pkg::DataWidth-1:0] req_divisor,
   output logic                          rsp_valid,
   output logic [dmc_pkg::DataWidth-1:0] rsp_result
);
   import dmc_pkg::*;

   logic                 busy_ff;
   logic [StepCount:0]   chain_valid;
   stage_type            chain_stage [StepCount+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   dmc_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .accept       (start & ~busy_ff),
      .req_mode     (req_mode),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .dn_valid     (chain_valid[0]),
      .dn_stage     (chain_stage[0])
   );

   for (genvar i = 0; i < StepCount; i++) begin : g_step
      dmc_step u_step (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_stage (chain_stage[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_stage (chain_stage[i+1])
      );
   end

   dmc_post u_post (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (chain_valid[StepCount]),
      .up_stage   (chain_stage[StepCount]),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

endmodule

// ===== src/dmc_prep.sv =====
// Entry stage: registers an accepted item and takes operand magnitudes.
// Depends on dmc_pkg.
module dmc_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [1:0]                    req_mode,
   input  logic [dmc_pkg::DataWidth-1:0] req_dividend,
   input  logic [dmc_pkg::DataWidth-1:0] req_divisor,
   output logic                          dn_valid,
   output dmc_pkg::stage_type            dn_stage
);
   import dmc_pkg::*;

   logic      valid_ff;
   stage_type step_ff;
   stage_type step_in;
   logic      is_signed;

   always_comb begin
      step_in.mode = mode_type'(req_mode);
      is_signed = (step_in.mode == MODE_SDIV) || (step_in.mode == MODE_SREM);
      step_in.neg_a = is_signed & req_dividend[DataWidth-1];
      step_in.neg_b = is_signed & req_divisor[DataWidth-1];
      step_in.zero_div = (req_divisor == '0);
      step_in.rem = '0;
      // -2^63 negates to its own bit pattern, which is the wanted magnitude
      step_in.work = step_in.neg_a ? (~req_dividend + 1'b1) : req_dividend;
      step_in.divisor = step_in.neg_b ? (~req_divisor + 1'b1) : req_divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         step_ff <= step_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_stage = step_ff;

endmodule

// ===== src/dmc_step.sv =====
// One restoring division step: shift in a dividend bit, trial subtract, register.
// Depends on dmc_pkg.
module dmc_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   input  dmc_pkg::stage_type up_stage,
   output logic               dn_valid,
   output dmc_pkg::stage_type dn_stage
);
   import dmc_pkg::*;

   logic                  valid_ff;
   stage_type             step_ff;
   stage_type             step_in;
   logic [DataWidth+1:0]  trial;
   logic                  take;

   always_comb begin
      // partial remainder is 65 bits after the shift; its top bit is rem[63]
      trial = {1'b0, up_stage.rem, up_stage.work[DataWidth-1]} - {2'b00, up_stage.divisor};
      take = ~trial[DataWidth+1];
      step_in = up_stage;
      step_in.rem = take ? trial[DataWidth-1:0]
                         : {up_stage.rem[DataWidth-2:0], up_stage.work[DataWidth-1]};
      step_in.work = {up_stage.work[DataWidth-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid) begin
         step_ff <= step_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_stage = step_ff;

endmodule

// ===== src/dmc_post.sv =====
// Exit stage: picks quotient or remainder, restores sign (zero for a zero divisor), registers the result.
// Depends on dmc_pkg.
module dmc_post (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   input  dmc_pkg::stage_type            up_stage,
   output logic                          rsp_valid,
   output logic [dmc_pkg::DataWidth-1:0] rsp_result
);
   import dmc_pkg::*;

   logic                 valid_ff;
   logic [DataWidth-1:0] result_ff;
   logic [DataWidth-1:0] result_in;
   logic                 negate;
   logic [DataWidth-1:0] pick;

   always_comb begin
      unique case (up_stage.mode)
         MODE_UDIV: begin
            pick = up_stage.work;
            negate = 1'b0;
         end
         MODE_UREM: begin
            pick = up_stage.rem;
            negate = 1'b0;
         end
         MODE_SDIV: begin
            pick = up_stage.work;
            negate = up_stage.neg_a ^ up_stage.neg_b;
         end
         MODE_SREM: begin
            pick = up_stage.rem;
            negate = up_stage.neg_a;
         end
      endcase
      if (up_stage.zero_div) begin
         result_in = '0;
      end else if (negate) begin
         result_in = ~pick + 1'b1;
      end else begin
         result_in = pick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for int64_divide_modulo_core: directed corner items, then random
// items with idle gaps, every result compared against a local divide/modulo predictor.
// Depends on dmc_pkg and the core RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dmc_pkg::*;

   localparam int DirectedCount = 24;
   localparam int RandomCount   = 550;
   localparam int IdleLimit     = 2000;
   localparam int TailCycles    = 80;

   typedef struct {
      mode_type          mode;
      logic [63:0]       dividend;
      logic [63:0]       divisor;
      int unsigned       gap;     // idle cycles after this item is taken
      bit                drain;   // hold off until all results are back
   } div_item_type;

   typedef struct {
      mode_type          mode;
      logic [63:0]       dividend;
      logic [63:0]       divisor;
      logic [63:0]       result;
   } div_answer_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_mode = MODE_UDIV;
   logic [63:0]       req_dividend = '0;
   logic [63:0]       req_divisor = '0;
   logic              rsp_valid;
   logic [63:0]       rsp_result;

   div_item_type      item_q[$];
   div_answer_type    answer_q[$];
   int                item_total = 0;
   int                items_taken = 0;
   int                results_seen = 0;
   int                error_count = 0;
   int                zero_div_count = 0;
   int                mode_count[4] = '{0, 0, 0, 0};
   int unsigned       hold = 0;
   int                idle_cycles = 0;

   int64_divide_modulo_core dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .rsp_valid    (rsp_valid),
      .rsp_result   (rsp_result)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Signed modes divide magnitudes; the most negative value's magnitude is its own pattern.
   function automatic logic [63:0] divmod_expected(mode_type m, logic [63:0] a,
                                                   logic [63:0] b);
      logic        signed_op;
      logic        neg_a;
      logic        neg_b;
      logic [63:0] mag_a;
      logic [63:0] mag_b;
      logic [63:0] quo;
      logic [63:0] rem;
      signed_op = (m == MODE_SDIV) || (m == MODE_SREM);
      neg_a = signed_op && a[63];
      neg_b = signed_op && b[63];
      mag_a = neg_a ? 64'd0 - a : a;
      mag_b = neg_b ? 64'd0 - b : b;
      if (mag_b == 64'd0) return 64'd0;
      quo = mag_a / mag_b;
      rem = mag_a % mag_b;
      case (m)
         MODE_UDIV: return quo;
         MODE_UREM: return rem;
         MODE_SDIV: return (neg_a != neg_b) ? 64'd0 - quo : quo;
         default:   return neg_a ? 64'd0 - rem : rem;
      endcase
   endfunction

   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, 15);
         1: v = v >> $urandom_range(1, 63);
         2: v = 64'd0 - $urandom_range(1, 15);
         3: v = 64'h8000_0000_0000_0000 ^ $urandom_range(0, 3);
         4: v = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
         5: v = 64'd1 << $urandom_range(0, 63);
         6: v = 64'd0 - (v >> $urandom_range(1, 63));
         default: ;
      endcase
      return v;
   endfunction

   task automatic add_item(mode_type m, logic [63:0] a, logic [63:0] b,
                           int unsigned gap, bit drain);
      div_item_type it;
      it.mode = m;
      it.dividend = a;
      it.divisor = b;
      it.gap = gap;
      it.drain = drain;
      item_q.push_back(it);
      item_total++;
   endtask

   task automatic note_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Driver: takes items from item_q, honors per-item gaps and drain requests.
   always @(posedge clock) begin
      div_item_type   it;
      div_answer_type ans;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            ans.mode = mode_type'(req_mode);
            ans.dividend = req_dividend;
            ans.divisor = req_divisor;
            ans.result = divmod_expected(ans.mode, req_dividend, req_divisor);
            answer_q.push_back(ans);
            items_taken++;
            mode_count[req_mode]++;
            if (req_divisor == 64'd0) zero_div_count++;
         end
         if (!start || !busy) begin
            if (hold > 0) begin
               hold--;
               start <= 1'b0;
            end else if (item_q.size() != 0 &&
                         !(item_q[0].drain && answer_q.size() != 0)) begin
               it = item_q.pop_front();
               req_mode <= it.mode;
               req_dividend <= it.dividend;
               req_divisor <= it.divisor;
               start <= 1'b1;
               hold = it.gap;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each strobe is checked against the oldest outstanding item.
   always @(posedge clock) begin
      div_answer_type ans;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (answer_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result %h", rsp_result));
         end else begin
            ans = answer_q.pop_front();
            if (rsp_result !== ans.result)
               note_mismatch($sformatf("%s %h by %h: result %h, want %h", ans.mode.name(),
                                       ans.dividend, ans.divisor, rsp_result, ans.result));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
         $display("timeout: no handshake for %0d cycles", IdleLimit);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [63:0] a;
      logic [63:0] b;
      bit          gaps_on;
      // directed corners: zero divisor, overflow, sign combinations, huge divisors
      add_item(MODE_UDIV, 64'd12345, 64'd0, 0, 1'b0);
      add_item(MODE_UREM, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 0, 1'b0);
      add_item(MODE_SDIV, 64'h8000_0000_0000_0000, 64'd0, 1, 1'b0);
      add_item(MODE_SREM, 64'hFFFF_FFFF_FFFF_FFF9, 64'd0, 0, 1'b0);
      add_item(MODE_SDIV, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
      add_item(MODE_SREM, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 2, 1'b0);
      add_item(MODE_UDIV, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 0, 1'b0);
      add_item(MODE_UREM, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
      add_item(MODE_UDIV, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 0, 1'b0);
      add_item(MODE_UREM, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 3, 1'b0);
      add_item(MODE_UDIV, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 0, 1'b0);
      add_item(MODE_UDIV, 64'd0, 64'd7, 0, 1'b0);
      add_item(MODE_UREM, 64'd5, 64'd9, 0, 1'b0);
      add_item(MODE_SDIV, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2, 0, 1'b0);
      add_item(MODE_SDIV, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE, 0, 1'b0);
      add_item(MODE_SDIV, 64'hFFFF_FFFF_FFFF_FFF9, 64'hFFFF_FFFF_FFFF_FFFE, 4, 1'b0);
      add_item(MODE_SREM, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2, 0, 1'b0);
      add_item(MODE_SREM, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE, 0, 1'b0);
      add_item(MODE_SREM, 64'hFFFF_FFFF_FFFF_FFF9, 64'hFFFF_FFFF_FFFF_FFFE, 0, 1'b0);
      // negative dividend, exact division: remainder is zero, not negative zero
      add_item(MODE_SREM, 64'hFFFF_FFFF_FFFF_FFFA, 64'd3, 0, 1'b0);
      add_item(MODE_SDIV, 64'd3, 64'hFFFF_FFFF_FFFF_FFFA, 0, 1'b0);
      add_item(MODE_SDIV, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 0, 1'b0);
      add_item(MODE_SREM, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1'b0);
      add_item(MODE_UDIV, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 16, 1'b0);

      gaps_on = 1'b0;
      for (int i = 0; i < RandomCount; i++) begin
         if (i % 40 == 0) gaps_on = $urandom_range(0, 1);
         a = random_operand();
         case ($urandom_range(0, 11))
            0:       b = 64'd0;
            1:       b = $urandom_range(0, 1) ? 64'd1 : 64'hFFFF_FFFF_FFFF_FFFF;
            2:       b = a;
            3:       b = a + 64'd1;
            default: b = random_operand();
         endcase
         add_item(mode_type'($urandom_range(0, 3)), a, b,
                  gaps_on ? $urandom_range(0, 16) : 0, (i % 150 == 0));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (items_taken < item_total) @(posedge clock);
      while (answer_q.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      $display("covered %0d items (udiv %0d, urem %0d, sdiv %0d, srem %0d), %0d by zero",
               items_taken, mode_count[MODE_UDIV], mode_count[MODE_UREM],
               mode_count[MODE_SDIV], mode_count[MODE_SREM], zero_div_count);
      $display("%0d results checked, %0d errors", results_seen, error_count);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
